// ===== hw/rtl/consistent_hash_ring_dispatch_unit_assert.svh =====
// assertion macros for the hash ring dispatch unit
`ifndef CONSISTENT_HASH_RING_DISPATCH_UNIT_ASSERT_SVH
`define CONSISTENT_HASH_RING_DISPATCH_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define CHR_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);
// next-cycle implication
`define CHR_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);
`endif

// ===== hw/rtl/chr_pkg.sv =====
// shared types, constants and crc function for the hash ring dispatch unit
`default_nettype none
package chr_pkg;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [1:0] ST_LOOKUP = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ADDED  = 2'd3;
	localparam logic [8:0] SERVER_SAT = 9'd511;

	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [7:0]  server_id;
		logic [12:0] point_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  chosen_server;
		logic [12:0] entries_used;
	} rsp_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return ~c;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/chr_ring_mem.sv =====
// ring table memory: point and server per entry, one write and one read port
`default_nettype none
module chr_ring_mem #(
	parameter int RING_DEPTH  = 4096,
	parameter int SERVER_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(RING_DEPTH)-1:0] waddr,
	input  wire logic [31:0]                   wpoint,
	input  wire logic [SERVER_BITS-1:0]        wserver,
	input  wire logic [$clog2(RING_DEPTH)-1:0] raddr,
	output logic      [31:0]                   rpoint,
	output logic      [SERVER_BITS-1:0]        rserver
);
	import chr_pkg::*;
	logic [31:0]            points_q  [RING_DEPTH];
	logic [SERVER_BITS-1:0] servers_q [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			points_q[waddr]  <= wpoint;
			servers_q[waddr] <= wserver;
		end
		rpoint  <= points_q[raddr];
		rserver <= servers_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/consistent_hash_ring_dispatch_unit.sv =====
// top level of the consistent hash ring dispatch unit
`default_nettype none
// Consistent-hash ring with crc-32 points. Each non-final byte is a crc update in the
// crc register. A final key byte then runs a binary search over the sorted table in
// the memory, each probe a read and then a compare of the read data. A final server
// byte makes point_count points; each point takes a crc over the four bytes of the
// previous point, a binary search and a shift of the entries above it, each entry read
// and then written one place up through the memory's read and write port, before the
// new point is written. The block takes no request while an item end is in work and
// while a result waits to be taken. The table needs no clearing after reset; only
// entries below the fill count are read.
module consistent_hash_ring_dispatch_unit #(
	parameter int RING_DEPTH  = 4096,
	parameter int SERVER_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire chr_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output chr_pkg::rsp_t      out_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [31:0]   cfg_data
);
	import chr_pkg::*;
	`include "consistent_hash_ring_dispatch_unit_assert.svh"

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = AW + 1;

	// one-hot sequencer
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PCRC   = 9'b000000010, // crc one point byte
		S_SRCH   = 9'b000000100, // issue probe read
		S_SCMP   = 9'b000001000, // compare probe data
		S_SHRD   = 9'b000010000, // read entry to move up
		S_SHWR   = 9'b000100000, // write it one place up
		S_INS    = 9'b001000000, // write new point
		S_LKRD   = 9'b010000000, // take lookup answer
		S_OUT    = 9'b100000000  // result waiting
	} state_t;

	state_t                 state_q;
	logic [31:0]            seed_q;
	logic [31:0]            crc_q;        // running name or key crc
	logic                   busy_q;       // item started
	logic [31:0]            point_q;      // previous point / working crc
	logic [31:0]            wpoint_acc_q; // crc over point bytes in progress
	logic [1:0]             pbyte_q;      // point byte index
	logic [CW-1:0]          lo_q, hi_q;
	logic                   is_add_q;
	logic [CW-1:0]          left_q;       // points still to make
	logic [SERVER_BITS-1:0] sid_q;
	logic [CW-1:0]          total_q;
	logic [8:0]             servers_q;
	logic [CW-1:0]          mv_q;         // shift cursor
	rsp_t                   rsp_q;

	logic                   we;
	logic [AW-1:0]          waddr, raddr;
	logic [31:0]            wpoint, rpoint;
	logic [SERVER_BITS-1:0] wserver, rserver;
	logic [CW-1:0]          mid;
	logic [31:0]            crc_in, next_crc;
	logic [7:0]             pb;
	logic                   go_right;

	chr_ring_mem #(.RING_DEPTH(RING_DEPTH), .SERVER_BITS(SERVER_BITS)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wpoint(wpoint), .wserver(wserver),
		.raddr(raddr), .rpoint(rpoint), .rserver(rserver)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !busy_q;
	assign out_valid = (state_q == S_OUT);
	assign out_data  = rsp_q;

	// binary search midpoint
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	// add searches for first point > p, lookup for first point >= p
	assign go_right = is_add_q ? (rpoint <= point_q) : (rpoint < crc_q);

	// the one shared crc byte unit
	assign crc_in = busy_q ? crc_q : (in_data.command ? 32'd0 : seed_q);
	always_comb begin
		case (pbyte_q)
			2'd0:    pb = point_q[7:0];
			2'd1:    pb = point_q[15:8];
			2'd2:    pb = point_q[23:16];
			default: pb = point_q[31:24];
		endcase
	end
	assign next_crc = crc_byte((state_q == S_PCRC) ? (pbyte_q == 2'd0 ? crc_q : wpoint_acc_q)
		: crc_in, (state_q == S_PCRC) ? pb : in_data.data_byte);

	always_comb begin
		we      = 1'b0;
		waddr   = mv_q[AW-1:0];
		wpoint  = rpoint;
		wserver = rserver;
		raddr   = mid[AW-1:0];
		case (state_q)
			// probe read while the search runs; when it is done, fetch the answer entry, wrapping to the first one
			S_SRCH:  raddr = (lo_q < hi_q) ? mid[AW-1:0]
				: ((lo_q >= total_q) ? '0 : lo_q[AW-1:0]);
			S_SHRD:  raddr = AW'(mv_q - CW'(1));
			S_SHWR:  we = 1'b1;
			S_INS: begin
				we      = 1'b1;
				waddr   = lo_q[AW-1:0];
				wpoint  = point_q;
				wserver = sid_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			seed_q    <= '0;
			busy_q    <= 1'b0;
			total_q   <= '0;
			servers_q <= '0;
			rsp_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) seed_q <= cfg_data;
					if (in_valid) begin
						crc_q  <= next_crc;
						busy_q <= !in_data.last_byte;
						if (in_data.last_byte) begin
							is_add_q <= in_data.command;
							sid_q    <= in_data.server_id[SERVER_BITS-1:0];
							left_q   <= CW'(in_data.point_count);
							point_q  <= '0;
							pbyte_q  <= '0;
							rsp_q.chosen_server <= '0;
							rsp_q.entries_used  <= 13'(total_q);
							if (in_data.command) begin
								if (32'(in_data.point_count) > 32'(RING_DEPTH) - 32'(total_q)) begin
									rsp_q.status <= ST_FULL;
									state_q      <= S_OUT;
								end else if (in_data.point_count == 13'd0) begin
									if (servers_q != SERVER_SAT) servers_q <= servers_q + 9'd1;
									rsp_q.status <= ST_ADDED;
									state_q      <= S_OUT;
								end else begin
									state_q <= S_PCRC;
								end
							end else if (servers_q == 9'd0 || total_q == '0) begin
								rsp_q.status <= ST_EMPTY;
								state_q      <= S_OUT;
							end else begin
								lo_q    <= '0;
								hi_q    <= total_q;
								state_q <= S_SRCH;
							end
						end
					end
				end
				S_PCRC: begin
					wpoint_acc_q <= next_crc;
					pbyte_q      <= pbyte_q + 2'd1;
					if (pbyte_q == 2'd3) begin
						point_q <= next_crc;
						lo_q    <= '0;
						hi_q    <= total_q;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) state_q <= S_SCMP;
					else if (is_add_q) begin
						mv_q    <= total_q;
						state_q <= (total_q == lo_q) ? S_INS : S_SHRD;
					end else state_q <= S_LKRD;
				end
				S_SCMP: begin
					if (go_right) lo_q <= mid + CW'(1);
					else hi_q <= mid;
					state_q <= S_SRCH;
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					mv_q    <= mv_q - CW'(1);
					state_q <= (mv_q - CW'(1) == lo_q) ? S_INS : S_SHRD;
				end
				S_INS: begin
					total_q <= total_q + CW'(1);
					left_q  <= left_q - CW'(1);
					pbyte_q <= '0;
					if (left_q == CW'(1)) begin
						if (servers_q != SERVER_SAT) servers_q <= servers_q + 9'd1;
						rsp_q.status       <= ST_ADDED;
						rsp_q.entries_used <= 13'(total_q + CW'(1));
						state_q            <= S_OUT;
					end else state_q <= S_PCRC;
				end
				S_LKRD: begin
					rsp_q.status        <= ST_LOOKUP;
					rsp_q.chosen_server <= 8'(rserver);
					state_q             <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CHR_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, total_q <= CW'(RING_DEPTH),
		"fill count beyond table depth")
	`CHR_ASSERT_IMP(a_out_state, clk, arst_n, out_valid, !in_stall == 1'b0,
		"result shown while taking requests")
	`CHR_ASSERT_IMP(a_search_range, clk, arst_n, state_q == S_SCMP, lo_q < hi_q && hi_q <= total_q,
		"probe outside search range")
endmodule
`default_nettype wire

// ===== bench/consistent_hash_ring_dispatch_unit_test.sv =====
// self-checking bench for the consistent hash ring dispatch unit
module consistent_hash_ring_dispatch_unit_test;
	import chr_pkg::*;

	localparam int DEPTH = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	consistent_hash_ring_dispatch_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// requests waiting to be offered, and responses the ring should give
	req_t pending_q[$];
	rsp_t expected_rsp_q[$];
	int mismatches = 0;
	bit quiet = 1'b0; // no random gaps on either side while set

	// mirror of the ring
	logic [31:0] seed_m = '0;
	logic [31:0] name_crc_m = '0;
	bit item_open = 1'b0;
	logic [31:0] ring_pts[DEPTH];
	logic [7:0] ring_srv[DEPTH];
	int fill_m = 0;
	int servers_m = 0;

	// generator side copy of the fill count, to pick add sizes
	int planned_fill = 0;

	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc;
		c[7:0] = c[7:0] ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ 32'hEDB88320;
			else
				c = c >> 1;
		end
		return ~c;
	endfunction

	task automatic insert_points(input logic [31:0] ncrc, input int count, input logic [7:0] sid);
		logic [31:0] pt;
		int pos;
		pt = '0;
		for (int i = 0; i < count; i++) begin
			pt = crc_step(crc_step(crc_step(crc_step(ncrc, pt[7:0]), pt[15:8]),
				pt[23:16]), pt[31:24]);
			// after any equal points
			pos = 0;
			while (pos < fill_m && ring_pts[pos] <= pt)
				pos++;
			for (int j = fill_m; j > pos; j--) begin
				ring_pts[j] = ring_pts[j-1];
				ring_srv[j] = ring_srv[j-1];
			end
			ring_pts[pos] = pt;
			ring_srv[pos] = sid;
			fill_m++;
		end
	endtask

	task automatic predict_request(input req_t r);
		rsp_t e;
		int pos;
		if (!item_open) begin
			name_crc_m = r.command ? 32'd0 : seed_m;
			item_open = 1'b1;
		end
		name_crc_m = crc_step(name_crc_m, r.data_byte);
		if (!r.last_byte)
			return;
		item_open = 1'b0;
		e = '0;
		if (r.command) begin
			if (int'(r.point_count) > DEPTH - fill_m) begin
				e.status = ST_FULL;
			end else begin
				insert_points(name_crc_m, int'(r.point_count), r.server_id);
				if (servers_m < 511)
					servers_m++;
				e.status = ST_ADDED;
			end
		end else if (servers_m == 0 || fill_m == 0) begin
			e.status = ST_EMPTY;
		end else begin
			pos = 0;
			while (pos < fill_m && ring_pts[pos] < name_crc_m)
				pos++;
			if (pos >= fill_m)
				pos = 0;
			e.status = ST_LOOKUP;
			e.chosen_server = ring_srv[pos];
		end
		e.entries_used = 13'(fill_m);
		expected_rsp_q.push_back(e);
	endtask

	// driver: offers queued requests with a random gap after each, none while quiet
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		bit take;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap <= 0;
		end else begin
			take = in_valid && !in_stall;
			if (take)
				predict_request(in_data);
			if (!in_valid || take) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					in_data <= pending_q.pop_front();
					in_valid <= 1'b1;
					gap <= quiet ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off on the response side, counted here in its own process
	int cyc = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cyc <= 0;
		else
			cyc <= cyc + 1;
	end
	wire hold_off = (cyc >= 3000 && cyc < 3400);

	// monitor: checks each taken response against the oldest expectation
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		int n;
		rsp_t e;
		if (!arst_n) begin
			out_stall <= 1'b1;
			stall_left <= 0;
		end else begin
			n = stall_left;
			if (out_valid && !out_stall) begin
				if (expected_rsp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response %p", out_data);
				end else begin
					e = expected_rsp_q.pop_front();
					if (out_data.status !== e.status || out_data.chosen_server !== e.chosen_server
						|| out_data.entries_used !== e.entries_used) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", e, out_data);
					end
				end
				n = quiet ? 0 : $urandom_range(0, 5);
			end else if (n > 0) begin
				n--;
			end
			stall_left <= n;
			out_stall <= (n != 0) || hold_off;
		end
	end

	// name of a server: host bytes, a zero byte, port bytes
	task automatic queue_add(input int count, input logic [7:0] sid);
		req_t r;
		int hlen;
		int plen;
		hlen = $urandom_range(1, 6);
		plen = $urandom_range(1, 4);
		for (int i = 0; i < hlen + 1 + plen; i++) begin
			r = '0;
			r.command = 1'b1;
			r.data_byte = (i == hlen) ? 8'h00 : 8'($urandom_range(1, 255));
			r.server_id = 8'($urandom);
			r.point_count = 13'($urandom);
			if (i == hlen + plen) begin
				r.last_byte = 1'b1;
				r.server_id = sid;
				r.point_count = 13'(count);
			end
			pending_q.push_back(r);
		end
		if (count <= DEPTH - planned_fill)
			planned_fill += count;
	endtask

	// key bytes; mixed sets a random command on the non-final bytes
	task automatic queue_key(input int len, input bit mixed, input logic [7:0] fixed_byte,
		input bit use_fixed);
		req_t r;
		for (int i = 0; i < len; i++) begin
			r = '0;
			r.command = mixed ? 1'($urandom) : 1'b0;
			r.data_byte = use_fixed ? fixed_byte : 8'($urandom);
			r.server_id = 8'($urandom);
			r.point_count = 13'($urandom);
			r.last_byte = (i == len - 1);
			if (r.last_byte)
				r.command = 1'b0;
			pending_q.push_back(r);
		end
	endtask

	// pick an add size that keeps the ring small, or one that overflows
	function automatic int add_size();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(DEPTH + 1 - planned_fill, DEPTH);
		if (planned_fill > 300)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	task automatic queue_random(input int byte_budget);
		int start;
		int pick;
		start = pending_q.size();
		while (pending_q.size() - start < byte_budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				queue_key($urandom_range(1, 8), 1'b0, 8'h00, 1'b0);
			else if (pick < 90)
				queue_add(add_size(), 8'($urandom));
			else if (pick < 95)
				queue_key($urandom_range(2, 6), 1'b1, 8'h00, 1'b0);
			else
				queue_add(add_size(), 8'($urandom)); // reuse of a name is allowed too
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() > 0 || in_valid || expected_rsp_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		seed_m = v;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_seed(32'h0000_0000);

		// directed: empty ring, zero-point add, byte extremes, overflow, mixed commands
		queue_key(1, 1'b0, 8'h00, 1'b1);
		queue_add(0, 8'h00);
		queue_key(2, 1'b0, 8'hFF, 1'b1);
		queue_add(5, 8'hFF);
		queue_add(3, 8'h00);
		queue_key(1, 1'b0, 8'h00, 1'b1);
		queue_key(3, 1'b0, 8'hFF, 1'b1);
		queue_add(DEPTH, 8'hA5);
		queue_add(DEPTH - planned_fill + 1, 8'h5A);
		queue_add(1, 8'h80);
		queue_key(4, 1'b1, 8'h00, 1'b0);
		queue_key(2, 1'b0, 8'h00, 1'b0);
		wait_drained();

		queue_random(650);
		wait_drained();
		write_seed(32'hFFFF_FFFF);
		quiet = 1'b1;
		queue_random(200);
		wait_drained();
		quiet = 1'b0;
		queue_random(450);
		wait_drained();
		write_seed($urandom);
		queue_random(650);
		wait_drained();

		if (mismatches == 0 && expected_rsp_q.size() == 0)
			$display("consistent_hash_ring_dispatch_unit test passed");
		else
			$display("consistent_hash_ring_dispatch_unit test failed");
		$finish;
	end

	initial begin
		#24000000;
		$display("consistent_hash_ring_dispatch_unit test failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/chr_pkg.sv
hw/rtl/chr_ring_mem.sv
hw/rtl/consistent_hash_ring_dispatch_unit.sv
bench/consistent_hash_ring_dispatch_unit_test.sv
